[sv/xrg_pkg.sv]
// Shared constants, codes and helpers for the xoshiro random generator.
`timescale 1ns / 1ps
package xrg_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CoordW = 32;
  localparam int unsigned ActW = 2;
  localparam int unsigned FracShift = 11;

  localparam logic [WordW-1:0] GoldenStep = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixMulA    = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MixMulB    = 64'h94d049bb133111eb;
  localparam logic [WordW-1:0] CoordMulX  = 64'h517cc1b727220a95;
  localparam logic [WordW-1:0] CoordMulY  = 64'h6c62272e07bb0142;
  localparam logic [WordW-1:0] CoordMulZ  = 64'h9e3779b97f4a7c15;

  localparam logic [ActW-1:0] ActRaw     = 2'd0;
  localparam logic [ActW-1:0] ActFrac    = 2'd1;
  localparam logic [ActW-1:0] ActBounded = 2'd2;
  localparam logic [ActW-1:0] ActReseed  = 2'd3;

  // status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned k);
    rotl = (v << k) | (v >> (WordW - k));
  endfunction

endpackage

[sv/xrg_mul.sv]
// Iterative 64x64 multiplier, low half of the product, 16 multiplier bits per cycle.
`timescale 1ns / 1ps
module xrg_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [xrg_pkg::WordW-1:0]   a_i,
  input  logic [xrg_pkg::WordW-1:0]   b_i,
  output logic [xrg_pkg::WordW-1:0]   prod_o,
  output xrg_pkg::unit_stat_t         stat_o
);

  logic [xrg_pkg::WordW-1:0] a_q, b_q, acc_q;
  logic [1:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [xrg_pkg::WordW-1:0] part;

  assign part = a_q * {48'd0, b_q[15:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + part;
      a_q   <= a_q << 16;
      b_q   <= b_q >> 16;
    end
  end

  assign prod_o = acc_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

[sv/xrg_div.sv]
// Restoring 64-bit remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module xrg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [xrg_pkg::WordW-1:0]   dividend_i,
  input  logic [xrg_pkg::WordW-1:0]   divisor_i,
  output logic [xrg_pkg::WordW-1:0]   rem_o,
  output xrg_pkg::unit_stat_t         stat_o
);

  logic [xrg_pkg::WordW-1:0] rem_q, dvd_q, dvs_q;
  logic [5:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [xrg_pkg::WordW:0]   trial, diff;

  assign trial = {rem_q, dvd_q[xrg_pkg::WordW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      // remainder always stays below the divisor, so 64 bits suffice
      if (!diff[xrg_pkg::WordW]) rem_q <= diff[xrg_pkg::WordW-1:0];
      else rem_q <= trial[xrg_pkg::WordW-1:0];
    end
  end

  assign rem_o  = rem_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

[sv/xoshiro_random_generator.sv]
// Top level: xoshiro256** generator with raw, fraction, bounded and reseed requests.
// Usage: requests arrive on in_valid_i/in_ready_o with action_i, bound_i and the
// three coordinates; each transaction gives exactly one result on
// out_valid_o/out_ready_i (value_o). world_seed is written via cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, the block does not enforce it.
// One request at a time: in_ready_o is high only while the sequencer is idle.
// Raw draw and fraction take one generator step; reseed runs three coordinate
// multiplies, then four splitmix rounds of two multiplies each; a bounded draw
// runs two passes of the remainder unit plus one more draw per rejected draw;
// with bound zero the request goes straight to its zero result.
// After reset the generator expands seed zero through the same splitmix path
// with in_ready_o low.
// The result sits in an output register; a stalled receiver holds it there and
// the block takes the next request, but will not finish it until the held
// result has been taken.
`timescale 1ns / 1ps
module xoshiro_random_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [xrg_pkg::WordW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [xrg_pkg::ActW-1:0]          action_i,
  input  logic [xrg_pkg::WordW-1:0]         bound_i,
  input  logic signed [xrg_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [xrg_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [xrg_pkg::CoordW-1:0] coord_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [xrg_pkg::WordW-1:0]         value_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDraw  = 4'd1;
  localparam logic [3:0] StThr   = 4'd2;
  localparam logic [3:0] StBDraw = 4'd3;
  localparam logic [3:0] StMod   = 4'd4;
  localparam logic [3:0] StMix   = 4'd5;
  localparam logic [3:0] StSg0   = 4'd6;
  localparam logic [3:0] StSg1   = 4'd7;
  localparam logic [3:0] StSg2   = 4'd8;
  localparam logic [3:0] StDone  = 4'd9;

  logic [3:0]                 state_q;
  logic                       init_q;
  logic [1:0]                 idx_q;
  logic [xrg_pkg::ActW-1:0]   act_q;
  logic [xrg_pkg::WordW-1:0]  bound_q, thr_q, mixed_q, ctr_q, res_q, seed_q, value_q;
  logic [xrg_pkg::CoordW-1:0] cy_q, cz_q;
  logic [xrg_pkg::WordW-1:0]  w_q [4];
  logic                       out_valid_q;

  logic                       mul_start, div_start;
  logic [xrg_pkg::WordW-1:0]  mul_a, mul_b, div_a, div_b, prod, rem;
  xrg_pkg::unit_stat_t        mul_st, div_st;

  // scrambler and state update
  logic [xrg_pkg::WordW-1:0] s5, sr, draw, n0, n1, n2, n3, ctr_n, sm0, sm1, sm2;
  assign s5   = w_q[1] + (w_q[1] << 2);
  assign sr   = xrg_pkg::rotl(s5, 7);
  assign draw = sr + (sr << 3);
  assign n2   = w_q[2] ^ w_q[0];
  assign n3   = w_q[3] ^ w_q[1];
  assign n1   = w_q[1] ^ n2;
  assign n0   = w_q[0] ^ n3;
  assign ctr_n = ctr_q + xrg_pkg::GoldenStep;
  assign sm0  = ctr_n ^ (ctr_n >> 30);
  assign sm1  = prod ^ (prod >> 27);
  assign sm2  = prod ^ (prod >> 31);

  logic accept, out_free;
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = {32'd0, coord_x_i};
    mul_b     = xrg_pkg::CoordMulX;
    div_start = 1'b0;
    div_a     = '0 - bound_i;
    div_b     = bound_i;
    case (state_q)
      StIdle: begin
        if (accept && action_i == xrg_pkg::ActReseed) mul_start = 1'b1;
        if (accept && action_i == xrg_pkg::ActBounded && bound_i != '0) div_start = 1'b1;
      end
      StBDraw: begin
        div_a = draw;
        div_b = bound_q;
        div_start = (draw >= thr_q);
      end
      StMix: begin
        if (mul_st.done && idx_q != 2'd2) mul_start = 1'b1;
        if (idx_q == 2'd0) begin
          mul_a = {32'd0, cy_q};
          mul_b = xrg_pkg::CoordMulY;
        end else begin
          mul_a = {32'd0, cz_q};
          mul_b = xrg_pkg::CoordMulZ;
        end
      end
      StSg0: begin
        mul_start = 1'b1;
        mul_a     = sm0;
        mul_b     = xrg_pkg::MixMulA;
      end
      StSg1: begin
        mul_start = mul_st.done;
        mul_a     = sm1;
        mul_b     = xrg_pkg::MixMulB;
      end
      default: ;
    endcase
  end

  xrg_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .prod_o(prod), .stat_o(mul_st)
  );

  xrg_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .rem_o(rem), .stat_o(div_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StSg0;
      init_q      <= 1'b1;
      idx_q       <= '0;
      ctr_q       <= '0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) seed_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i && state_q != StDone) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            idx_q <= '0;
            case (action_i)
              xrg_pkg::ActRaw, xrg_pkg::ActFrac: state_q <= StDraw;
              xrg_pkg::ActBounded: state_q <= (bound_i == '0) ? StDone : StThr;
              default: state_q <= StMix;
            endcase
          end
        end
        StDraw: state_q <= StDone;
        StThr: if (div_st.done) state_q <= StBDraw;
        StBDraw: if (div_start) state_q <= StMod;
        StMod: if (div_st.done) state_q <= StDone;
        StMix: begin
          if (mul_st.done) begin
            if (idx_q == 2'd2) begin
              idx_q   <= '0;
              ctr_q   <= mixed_q ^ prod;
              state_q <= StSg0;
            end else idx_q <= idx_q + 2'd1;
          end
        end
        StSg0: begin
          ctr_q   <= ctr_n;
          state_q <= StSg1;
        end
        StSg1: if (mul_st.done) state_q <= StSg2;
        StSg2: begin
          if (mul_st.done) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q != 2'd3) state_q <= StSg0;
            else if (init_q) begin
              init_q  <= 1'b0;
              state_q <= StIdle;
            end else state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      bound_q <= bound_i;
      cy_q    <= coord_y_i;
      cz_q    <= coord_z_i;
      mixed_q <= seed_q;
      res_q   <= '0;
    end
    case (state_q)
      StDraw, StBDraw: begin
        if (state_q == StDraw) begin
          res_q <= (act_q == xrg_pkg::ActFrac) ? (draw >> xrg_pkg::FracShift) : draw;
        end
        w_q[0] <= n0;
        w_q[1] <= n1;
        w_q[2] <= n2 ^ (w_q[1] << 17);
        w_q[3] <= xrg_pkg::rotl(n3, 45);
      end
      StThr: if (div_st.done) thr_q <= rem;
      StMod: if (div_st.done) res_q <= rem;
      StMix: if (mul_st.done) mixed_q <= mixed_q ^ prod;
      StSg2: if (mul_st.done) w_q[idx_q] <= sm2;
      StDone: if (out_free) value_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  // the two arithmetic units are never in use at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mul_st.busy && div_st.busy))
    else $error("multiplier and divider busy together");

  // an accepted request always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> state_q != StIdle)
    else $error("request accepted but sequencer idle");

  // a finished result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_valid_q && !out_ready_i) |=> state_q == StDone)
    else $error("result overran output register");

  // generator words never collapse to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> ((w_q[0] | w_q[1] | w_q[2] | w_q[3]) != '0))
    else $error("generator words all zero");

endmodule

[tb/xoshiro_random_generator_tb.sv]
// Testbench for the xoshiro random generator: own generator model, scoreboard class, random stimulus.
`timescale 1ns / 1ps
module xoshiro_random_generator_tb;

  typedef logic [xrg_pkg::WordW-1:0] word_t;
  typedef logic [xrg_pkg::ActW-1:0] act_t;
  typedef logic [xrg_pkg::CoordW-1:0] coord_t;

  class draw_scoreboard;
    word_t gen_words[4];
    word_t seed_reg;
    word_t pending_values[$];
    int    err_cnt;

    function word_t rol(word_t v, int unsigned k);
      return (v << k) | (v >> (xrg_pkg::WordW - k));
    endfunction

    function word_t splitmix(ref word_t ctr);
      word_t m;
      ctr = ctr + xrg_pkg::GoldenStep;
      m = ctr;
      m = (m ^ (m >> 30)) * xrg_pkg::MixMulA;
      m = (m ^ (m >> 27)) * xrg_pkg::MixMulB;
      return m ^ (m >> 31);
    endfunction

    function void expand_seed(word_t s);
      word_t c;
      c = s;
      for (int i = 0; i < 4; i++) gen_words[i] = splitmix(c);
    endfunction

    function word_t next_raw();
      word_t o;
      word_t t;
      o = rol(gen_words[1] * 64'd5, 7) * 64'd9;
      t = gen_words[1] << 17;
      gen_words[2] ^= gen_words[0];
      gen_words[3] ^= gen_words[1];
      gen_words[1] ^= gen_words[2];
      gen_words[0] ^= gen_words[3];
      gen_words[2] ^= t;
      gen_words[3] = rol(gen_words[3], 45);
      return o;
    endfunction

    function new();
      seed_reg = '0;
      err_cnt = 0;
      expand_seed('0);
    endfunction

    function void note_request(act_t act, word_t bnd, coord_t cx, coord_t cy, coord_t cz);
      word_t v;
      word_t thr;
      word_t r;
      word_t mixed;
      v = '0;
      case (act)
        xrg_pkg::ActRaw: v = next_raw();
        xrg_pkg::ActFrac: v = next_raw() >> xrg_pkg::FracShift;
        xrg_pkg::ActBounded: begin
          if (bnd != '0) begin
            thr = (-bnd) % bnd;
            do r = next_raw(); while (r < thr);
            v = r % bnd;
          end
        end
        default: begin
          // coordinates join as zero-extended 32-bit patterns
          mixed = seed_reg ^ ({32'd0, cx} * xrg_pkg::CoordMulX)
                  ^ ({32'd0, cy} * xrg_pkg::CoordMulY)
                  ^ ({32'd0, cz} * xrg_pkg::CoordMulZ);
          expand_seed(mixed);
        end
      endcase
      pending_values.push_back(v);
    endfunction

    function void check_value(word_t act_v);
      word_t exp_v;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, act_v);
        err_cnt++;
        return;
      end
      exp_v = pending_values.pop_front();
      if (exp_v !== act_v) begin
        $display("%0t: value mismatch, expected %h, actual %h", $time, exp_v, act_v);
        err_cnt++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  word_t cfg_wdata;
  logic in_valid, in_ready;
  act_t action;
  word_t bound;
  logic signed [xrg_pkg::CoordW-1:0] cx, cy, cz;
  logic out_valid, out_ready;
  word_t value;

  draw_scoreboard sb;
  bit stim_done;
  bit long_hold;
  int unsigned hold_cycles;
  int unsigned idle_cycles;

  xoshiro_random_generator i_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .action_i(action), .bound_i(bound),
    .coord_x_i(cx), .coord_y_i(cy), .coord_z_i(cz),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .value_o(value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // valid stays high after acceptance only when the next request follows at once
  task automatic send_request(act_t a, word_t b, coord_t x, coord_t y, coord_t z);
    int unsigned gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    bound <= b;
    cx <= x;
    cy <= y;
    cz <= z;
    do @(posedge clk); while (!in_ready);
    sb.note_request(a, b, x, y, z);
  endtask

  task automatic write_seed(word_t s);
    // drain all results, then let the block settle before touching the register
    in_valid <= 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.seed_reg = s;
  endtask

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic word_t rand_bound();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return word_t'($urandom_range(1, 20));
      2: return word_t'(1) << $urandom_range(0, 63);
      3: return {1'b1, 63'(rand_word())};
      4: return word_t'($urandom());
      default: return rand_word();
    endcase
  endfunction

  task automatic random_request();
    act_t a;
    a = act_t'($urandom_range(0, 3));
    send_request(a, rand_bound(), $urandom(), $urandom(), $urandom());
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned w;
    out_ready = 1'b0;
    hold_cycles = 0;
    long_hold = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_ready && out_valid) begin
        sb.check_value(value);
        w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
        hold_cycles = w;
      end
      if (long_hold) begin
        long_hold = 1'b0;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // watchdog: cycles without any transaction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    action = xrg_pkg::ActRaw;
    bound = '0;
    cx = '0;
    cy = '0;
    cz = '0;
    stim_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    // directed part
    send_request(xrg_pkg::ActRaw, '0, '0, '0, '0);
    send_request(xrg_pkg::ActFrac, '1, '0, '0, '0);
    send_request(xrg_pkg::ActBounded, '0, '0, '0, '0);
    send_request(xrg_pkg::ActBounded, 64'd1, '0, '0, '0);
    send_request(xrg_pkg::ActBounded, '1, '0, '0, '0);
    send_request(xrg_pkg::ActBounded, 64'h8000_0000_0000_0001, '0, '0, '0);
    send_request(xrg_pkg::ActBounded, 64'd3, '1, '1, '1);
    send_request(xrg_pkg::ActReseed, '1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(xrg_pkg::ActRaw, '0, '0, '0, '0);
    send_request(xrg_pkg::ActReseed, '0, '0, '0, '0);
    send_request(xrg_pkg::ActFrac, '0, '1, '1, '1);
    write_seed('1);
    send_request(xrg_pkg::ActReseed, '0, 32'h7fff_ffff, 32'h8000_0000, 32'd1);
    send_request(xrg_pkg::ActRaw, '0, '0, '0, '0);
    send_request(xrg_pkg::ActBounded, 64'd7, '0, '0, '0);
    // long receiver hold-off while requests keep coming
    in_valid <= 1'b0;
    @(posedge clk);
    long_hold = 1'b1;
    for (int i = 0; i < 6; i++) send_request(xrg_pkg::ActRaw, '0, '0, '0, '0);
    // random part in phases with different seeds
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_seed('0);
        1: write_seed(64'h8000_0000_0000_0000);
        2: write_seed(64'd1);
        default: write_seed(rand_word());
      endcase
      for (int i = 0; i < 95; i++) random_request();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.err_cnt == 0 && sb.pending_values.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[sim.f]
sv/xrg_pkg.sv
sv/xrg_mul.sv
sv/xrg_div.sv
sv/xoshiro_random_generator.sv
tb/xoshiro_random_generator_tb.sv
